/* sv/prfl_pkg.sv */
// shared constants, types and helpers for the page replacement unit
package prfl_pkg;

  // number of page frames the store holds
  localparam int FRAMES = 16;
  localparam int PAGE_W = 32;
  localparam int PAGE_SH = $clog2(PAGE_W);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // configuration port
  localparam int LIM_W = 5;
  localparam int CFG_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CMP_W = (LIM_W > CNT_W) ? LIM_W : CNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 1'd1;

  localparam logic [LIM_W-1:0] FRAME_LIMIT_RST = 5'd16;

  // policy codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU = 1'b1;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // per-cycle control from the top level to the store
  typedef struct packed {
    logic step;
    logic lru;
    cnt_t lim;
  } prfl_ctl_t;

  // clamp the programmed frame limit into 1..FRAMES
  function automatic cnt_t eff_limit(input logic [LIM_W-1:0] fl);
    logic [CMP_W-1:0] w;
    cnt_t res;
    w = CMP_W'(fl);
    if (fl == '0) begin
      res = CNT_W'(1);
    end else if (w > CMP_W'(FRAMES)) begin
      res = CNT_W'(FRAMES);
    end else begin
      res = CNT_W'(w);
    end
    return res;
  endfunction

endpackage

/* sv/page_replacement_fifo_lru_unit.sv */
// top level of the fifo / lru page replacement unit
// Usage: each item on the input channel (in_valid, in_stall, in_page_number)
// is one page reference. For every item one result item leaves on the
// output channel (out_valid, out_stall, out_page_fault): 1 on a miss, 0 on
// a hit. Results come out in input order.
// There is one input register, then the lookup and store update feed the
// result register combinationally.
// Throughput is one item per cycle unless out_stall holds; the 16-way compare
// plus the barrel shift of the order store is the path that sets the cycle.
// Configuration (cfg_we, cfg_index, cfg_data): index 0 is the frame limit
// (clamped to 1..FRAMES), index 1 the policy (0 fifo, 1 lru). Write it only
// while no item is in flight.
// Reset empties the store, sets the limit to 16 and the policy to fifo.
// When out_stall holds the result register full, the input register keeps
// its item and in_stall rises until the result is taken.
module page_replacement_fifo_lru_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [31:0]                        in_page_number,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_page_fault,
  input  logic                               cfg_we,
  input  logic [prfl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prfl_pkg::CFG_W-1:0]         cfg_data
);
  import prfl_pkg::*;

  cnt_t      lim_r;
  logic      policy_r;
  logic      s1_valid_r;
  page_t     s1_page_r;
  logic      out_valid_r;
  logic      out_fault_r;
  logic      advance;
  logic      in_accept;
  logic      fault;
  prfl_ctl_t ctl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= eff_limit(FRAME_LIMIT_RST);
      policy_r <= POLICY_FIFO;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_LIMIT: lim_r <= eff_limit(cfg_data[LIM_W-1:0]);
        CFG_POLICY_MODE: policy_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_page_r <= in_page_number;
    end
  end

  // lookup and update
  assign ctl.step = advance;
  assign ctl.lru = policy_r;
  assign ctl.lim = lim_r;

  prfl_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .page  (s1_page_r),
    .fault (fault)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_fault_r <= fault;
    end
  end

  assign out_valid = out_valid_r;
  assign out_page_fault = out_fault_r;

`ifndef NO_ASSERTIONS
  a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
    lim_r != '0 && lim_r <= CNT_W'(FRAMES))
    else $error("effective frame limit out of range");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r && out_fault_r == $past(fault))
    else $error("result register did not take the item");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && s1_page_r == $past(s1_page_r))
    else $error("input register lost a held item");
`endif

endmodule

/* sv/prfl_store.sv */
// ordered page store with parallel lookup, eviction and reorder
module prfl_store (
  input  logic              clk,
  input  logic              rst_n,
  input  prfl_pkg::prfl_ctl_t ctl,
  input  prfl_pkg::page_t   page,
  output logic              fault
);
  import prfl_pkg::*;

  localparam int SH_W = CNT_W + PAGE_SH;

  logic [FRAMES-1:0][PAGE_W-1:0] pages_r;
  logic [FRAMES-1:0][PAGE_W-1:0] pages_nxt;
  logic [FRAMES-1:0][PAGE_W-1:0] shifted;
  cnt_t                          count_r;
  cnt_t                          count_nxt;
  logic [FRAMES-1:0]             match;
  logic                          hit;
  cnt_t                          pos;
  cnt_t                          shift;
  cnt_t                          start;
  cnt_t                          ins;
  logic                          write;
  logic [SH_W-1:0]               sh_bits;

  // compare every resident entry against the page
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = (CNT_W'(i) < count_r) && (pages_r[i] == page);
    end
  end

  assign hit = |match;
  assign fault = !hit;

  // lowest matching position
  always_comb begin
    pos = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = CNT_W'(i);
      end
    end
  end

  // shift amount, shift window and insert slot
  always_comb begin
    shift = '0;
    start = '0;
    ins = '0;
    write = 1'b0;
    count_nxt = count_r;
    if (ctl.step) begin
      if (hit) begin
        if (ctl.lru == POLICY_LRU) begin
          write = 1'b1;
          start = pos;
          shift = CNT_W'(1);
          ins = count_r - CNT_W'(1);
        end
      end else begin
        write = 1'b1;
        if (count_r >= ctl.lim) begin
          shift = count_r - ctl.lim + CNT_W'(1);
        end
        ins = count_r - shift;
        count_nxt = ins + CNT_W'(1);
      end
    end
  end

  // barrel shift of the whole store toward entry 0
  assign sh_bits = SH_W'(shift) << PAGE_SH;
  assign shifted = pages_r >> sh_bits;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      pages_nxt[i] = pages_r[i];
      if (write) begin
        if (CNT_W'(i) == ins) begin
          pages_nxt[i] = page;
        end else if ((CNT_W'(i) >= start) && (CNT_W'(i) < ins)) begin
          pages_nxt[i] = shifted[i];
        end
      end
    end
  end

  // store contents, no reset
  always_ff @(posedge clk) begin
    if (write) begin
      pages_r <= pages_nxt;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  logic [CNT_W-1:0] newest_pos;
  assign newest_pos = count_r - CNT_W'(1);

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FRAMES))
    else $error("store count above frame count");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step && hit |=> count_r == $past(count_r))
    else $error("hit changed the store count");

  a_miss_appends: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step && !hit |=> pages_r[newest_pos[IDX_W-1:0]] == $past(page))
    else $error("missed page not at newest end");

  a_miss_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step && !hit |=> count_r <= $past(ctl.lim) && count_r != '0)
    else $error("store count outside limit after miss");
`endif

endmodule

/* dv/page_replacement_fifo_lru_checker.sv */
// checker for the page replacement unit: models the resident store and scores every result item
`timescale 1ns / 1ps

module page_replacement_fifo_lru_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [31:0]                    in_page_number,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_page_fault,
  input  logic                           cfg_we,
  input  logic [prfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prfl_pkg::CFG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             faults_seen,
  output int                             hits_seen
);
  import prfl_pkg::*;

  // resident pages, oldest or least recent at the front
  page_t resident_q[$];
  // fault flags owed by the unit, in input order
  logic fault_due_q[$];
  logic [LIM_W-1:0] limit_reg;
  logic policy_reg;

  // print one line per mismatch and count it
  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // programmed limit clamped into the frames that exist
  function automatic int frames_in_use();
    int lim;
    lim = int'(limit_reg);
    if (lim < 1) lim = 1;
    if (lim > FRAMES) lim = FRAMES;
    return lim;
  endfunction

  // look one page up, update the store, return the fault flag
  function automatic logic touch_page(input page_t pg);
    int where;
    int lim;
    where = -1;
    foreach (resident_q[i]) begin
      if (where < 0 && resident_q[i] == pg) where = i;
    end
    if (where >= 0) begin
      // lru hit moves the page to the recent end, fifo hit leaves order alone
      if (policy_reg == POLICY_LRU) begin
        resident_q.delete(where);
        resident_q.push_back(pg);
      end
      return 1'b0;
    end
    // miss: evict from the old end until there is room, even if the limit shrank
    lim = frames_in_use();
    while (resident_q.size() >= lim) resident_q.delete(0);
    resident_q.push_back(pg);
    return 1'b1;
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin : watch
    logic fault_due;
    if (!rst_n) begin
      resident_q.delete();
      fault_due_q.delete();
      limit_reg = FRAME_LIMIT_RST;
      policy_reg = POLICY_FIFO;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FRAME_LIMIT) limit_reg = cfg_data[LIM_W-1:0];
        else if (cfg_index == CFG_POLICY_MODE) policy_reg = cfg_data[0];
      end
      // results first, so an early result cannot match the item taken this edge
      if (out_valid && !out_stall) begin
        if (fault_due_q.size() == 0) begin
          report_mismatch($sformatf("result item (fault %0b) with nothing expected",
                                    out_page_fault));
        end else begin
          fault_due = fault_due_q.pop_front();
          if (out_page_fault !== fault_due)
            report_mismatch($sformatf("page_fault %0b, expected %0b",
                                      out_page_fault, fault_due));
          if (fault_due) faults_seen++;
          else hits_seen++;
        end
      end
      if (in_valid && !in_stall) fault_due_q.push_back(touch_page(in_page_number));
    end
    pending = fault_due_q.size();
  end

endmodule

/* dv/tb_page_replacement_fifo_lru_unit.sv */
// testbench top for the page replacement unit: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_page_replacement_fifo_lru_unit;
  import prfl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 13;
  localparam int PHASE_REFS = 100;
  localparam int POOL_MAX = 24;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [31:0]          in_page_number;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_page_fault;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count;
  int pending;
  int faults_seen;
  int hits_seen;
  int cycles;
  int refs_sent;
  int reg_writes;
  bit idle_on;
  bit stall_on;
  page_t page_pool [POOL_MAX];
  int pool_n;

  page_replacement_fifo_lru_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_page_number (in_page_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_page_fault (out_page_fault),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  page_replacement_fifo_lru_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_page_number (in_page_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_page_fault (out_page_fault),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .faults_seen    (faults_seen),
    .hits_seen      (hits_seen)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: per item, when stall_on is set it may hold stall first, then take it
  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin : take_result
      int hold;
      hold = stall_on ? $urandom_range(0, 8) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  // offer one page reference, after a random gap when idle_on is set; entered and left at a falling edge
  task automatic send_page(input page_t pg);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_page_number <= pg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    refs_sent++;
  endtask

  // drop valid and wait until every result item has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // one register write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  // fresh set of pages for a phase, edge values mixed in
  task automatic fill_pool(input int n);
    pool_n = n;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: page_pool[i] = '0;
        1: page_pool[i] = '1;
        default: page_pool[i] = page_t'($urandom);
      endcase
    end
  endtask

  // mostly pool pages so hits happen, sometimes anything at all
  function automatic page_t pick_page();
    if ($urandom_range(0, 9) == 0) return page_t'($urandom);
    return page_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  // stimulus and verdict
  initial begin : stimulus
    logic [LIM_W-1:0] lim_pick;
    logic pol_pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_page_number = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_LIMIT;
    cfg_data = '0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: 16 frames, fifo; extreme pages miss then hit
    send_page('0);
    send_page('1);
    send_page('0);
    send_page('1);

    // three frames fifo: a hit does not refresh, the oldest page goes
    drain_results();
    cfg_write(CFG_FRAME_LIMIT, CFG_W'(3));
    cfg_write(CFG_POLICY_MODE, CFG_W'(POLICY_FIFO));
    send_page(32'd1);
    send_page(32'd2);
    send_page('1);
    send_page(32'd3);
    send_page('1);

    // switch to lru on a filled store: hit moves to recent end
    drain_results();
    cfg_write(CFG_POLICY_MODE, CFG_W'(POLICY_LRU));
    send_page(32'd2);
    send_page(32'd4);
    send_page(32'd3);

    // limit dropped below the count: hit keeps size, next miss shrinks to one
    drain_results();
    cfg_write(CFG_FRAME_LIMIT, CFG_W'(1));
    send_page(32'd2);
    send_page(32'd5);

    // limit zero acts as one
    drain_results();
    cfg_write(CFG_FRAME_LIMIT, CFG_W'(0));
    send_page(32'd5);
    send_page(32'd6);

    // limits above the frame count saturate
    drain_results();
    cfg_write(CFG_FRAME_LIMIT, CFG_W'(31));
    send_page(32'h8000_0000);
    send_page(32'h7fff_ffff);
    send_page(32'd6);
    drain_results();
    cfg_write(CFG_FRAME_LIMIT, CFG_W'(17));
    send_page(32'h5555_aaaa);

    // random phases, each with its own limit, policy and page set
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      case ($urandom_range(0, 5))
        0: lim_pick = LIM_W'(0);
        1: lim_pick = LIM_W'(1);
        2: lim_pick = LIM_W'(FRAMES);
        3: lim_pick = '1;
        default: lim_pick = LIM_W'($urandom_range(0, 31));
      endcase
      pol_pick = (ph % 2 == 0) ? POLICY_LRU : POLICY_FIFO;
      if ($urandom_range(0, 3) == 0) pol_pick = ~pol_pick;
      cfg_write(CFG_FRAME_LIMIT, CFG_W'(lim_pick));
      cfg_write(CFG_POLICY_MODE, CFG_W'(pol_pick));
      fill_pool($urandom_range(1, POOL_MAX));
      for (int k = 0; k < PHASE_REFS; k++) begin
        // redraw idling and stalling now and then so some stretches run flat out
        if (k % 25 == 0) begin
          idle_on = ($urandom_range(0, 2) != 0);
          stall_on = ($urandom_range(0, 2) != 0);
        end
        send_page(pick_page());
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    $display("%0d page references over %0d register writes (fifo and lru, limits 0 to 31)",
             refs_sent, reg_writes);
    $display("results checked: %0d faults, %0d hits, %0d mismatches",
             faults_seen, hits_seen, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/prfl_pkg.sv
sv/prfl_store.sv
sv/page_replacement_fifo_lru_unit.sv
dv/page_replacement_fifo_lru_checker.sv
dv/tb_page_replacement_fifo_lru_unit.sv
